@@ hdl/rse_pkg.sv @@
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// No dependencies; the encoder top level imports this package, the channel interfaces do not.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

  typedef logic [7:0] gf_t;

  // Default depth of the parity shift register.
  localparam int MAX_PARITY_DEF = 26;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PARITY_MODE = 1'b0;

  // Parity mode codes.
  localparam logic [1:0] MODE_P16 = 2'd0;
  localparam logic [1:0] MODE_P18 = 2'd1;
  localparam logic [1:0] MODE_P26 = 2'd2;

  localparam int NUM_P16 = 16;
  localparam int NUM_P18 = 18;
  localparam int NUM_P26 = 26;

  localparam gf_t GEN16 [NUM_P16] = '{
    8'd59, 8'd13, 8'd104, 8'd189, 8'd68, 8'd209, 8'd30, 8'd8,
    8'd163, 8'd65, 8'd41, 8'd229, 8'd98, 8'd50, 8'd36, 8'd59
  };
  localparam gf_t GEN18 [NUM_P18] = '{
    8'd215, 8'd234, 8'd158, 8'd94, 8'd184, 8'd97, 8'd118, 8'd170, 8'd79,
    8'd187, 8'd152, 8'd148, 8'd252, 8'd179, 8'd5, 8'd98, 8'd96, 8'd153
  };
  localparam gf_t GEN26 [NUM_P26] = '{
    8'd246, 8'd51, 8'd183, 8'd4, 8'd136, 8'd98, 8'd199, 8'd152, 8'd77,
    8'd56, 8'd206, 8'd24, 8'd145, 8'd40, 8'd209, 8'd117, 8'd233, 8'd42,
    8'd135, 8'd68, 8'd70, 8'd144, 8'd146, 8'd77, 8'd43, 8'd94
  };

  // Shift-and-add multiply; with one constant operand this folds to an XOR network.
  function automatic gf_t gf_mul(gf_t x, gf_t y);
    logic [8:0] a;
    gf_t        acc;
    a   = {1'b0, x};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ a[7:0];
      end
      a = {a[7:0], 1'b0};
      if (a[8]) begin
        a = a ^ FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // Generator coefficient j of a mode; zero past the end of its table.
  function automatic gf_t gen_coef(logic [1:0] mode, int j);
    gf_t c;
    c = '0;
    case (mode)
      MODE_P16: begin
        if (j < NUM_P16) c = GEN16[j];
      end
      MODE_P18: begin
        if (j < NUM_P18) c = GEN18[j];
      end
      default: begin
        if (j < NUM_P26) c = GEN26[j];
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rse_in_if.sv @@
// Input stream channel: one message byte per transfer, with end-of-block flag.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface rse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/rse_out_if.sv @@
// Result stream channel: one parity byte per transfer, with end-of-parity flag.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface rse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

`default_nettype wire

@@ hdl/reed_solomon_ecc_encoder.sv @@
// Top level of the systematic GF(256) Reed-Solomon parity encoder (QR-style).
// Depends on rse_pkg, rse_in_if and rse_out_if.
//
//   channel   dir   transfer payload                     flow control
//   in_chan   in    data_byte[7:0], last_byte            valid / ready
//   out_chan  out   parity_byte[7:0], last_parity        valid / ready
//   APB cfg   in    reg 0 @ 0x0: parity_mode[1:0]        psel/penable, pready tied high
//
// Cycles: a message byte is absorbed into the LFSR in the cycle it transfers, one per clock.
// A block's parity (16, 18 or 26 bytes) drains from a snapshot register, one byte per clock.
// The next block streams in while parity drains; only its last byte waits for the drain.
// Reset (synchronous, rst_n low) clears the LFSR and drops any pending parity; mode -> 26.
// Output stalls hold the snapshot; input stalls leave the LFSR untouched.
`timescale 1ns / 1ps
`default_nettype none

module reed_solomon_ecc_encoder #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rse_in_if.sink                             in_chan,
  rse_out_if.source                          out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rse_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rse_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rse_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import rse_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARITY + 1);

  // Parity counts per mode, clipped to the register depth.
  localparam int N16 = (NUM_P16 < MAX_PARITY) ? NUM_P16 : MAX_PARITY;
  localparam int N18 = (NUM_P18 < MAX_PARITY) ? NUM_P18 : MAX_PARITY;
  localparam int N26 = (NUM_P26 < MAX_PARITY) ? NUM_P26 : MAX_PARITY;

  logic [1:0]       mode_r;
  gf_t              lfsr_r   [MAX_PARITY];
  gf_t              lfsr_nxt [MAX_PARITY];
  gf_t              snap_r   [MAX_PARITY];
  logic [CNT_W-1:0] rem_r;
  logic             busy_r;
  logic [CNT_W-1:0] n_cur;
  gf_t              fb;
  logic             cfg_wr;
  logic             reg_idx;
  logic             in_fire;
  logic             out_fire;
  logic             drain_done;
  logic             load;

  // ---------------------------------------------------------------------------
  // Configuration port: writes land on the access phase; reads are immediate.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_P26;
    end else if (cfg_wr && (reg_idx == REG_PARITY_MODE)) begin
      mode_r <= pwdata[1:0];
    end
  end

  assign prdata = (reg_idx == REG_PARITY_MODE) ? {{(CFG_DATA_W-2){1'b0}}, mode_r} : '0;

  // Active parity count; the unused code behaves as the 26-byte mode.
  always_comb begin
    case (mode_r)
      MODE_P16: n_cur = CNT_W'(N16);
      MODE_P18: n_cur = CNT_W'(N18);
      default:  n_cur = CNT_W'(N26);
    endcase
  end

  // ---------------------------------------------------------------------------
  // LFSR step: feedback is the incoming byte XOR entry 0. Each tap below
  // the mode's length takes the entry above XOR feedback*g[j]; the top tap of
  // the mode takes feedback*g[n-1] alone; taps above the mode hold.
  // ---------------------------------------------------------------------------
  assign fb = in_chan.data_byte ^ lfsr_r[0];

  for (genvar J = 0; J < MAX_PARITY; J++) begin : g_tap
    localparam gf_t C16 = gen_coef(MODE_P16, J);
    localparam gf_t C18 = gen_coef(MODE_P18, J);
    localparam gf_t C26 = gen_coef(MODE_P26, J);
    gf_t up;
    gf_t v16;
    gf_t v18;
    gf_t v26;

    if (J + 1 < MAX_PARITY) begin : g_up
      assign up = lfsr_r[J+1];
    end else begin : g_top
      assign up = '0;
    end

    always_comb begin
      if (J < N16 - 1)       v16 = up ^ gf_mul(fb, C16);
      else if (J == N16 - 1) v16 = gf_mul(fb, C16);
      else                   v16 = lfsr_r[J];

      if (J < N18 - 1)       v18 = up ^ gf_mul(fb, C18);
      else if (J == N18 - 1) v18 = gf_mul(fb, C18);
      else                   v18 = lfsr_r[J];

      if (J < N26 - 1)       v26 = up ^ gf_mul(fb, C26);
      else if (J == N26 - 1) v26 = gf_mul(fb, C26);
      else                   v26 = lfsr_r[J];

      case (mode_r)
        MODE_P16: lfsr_nxt[J] = v16;
        MODE_P18: lfsr_nxt[J] = v18;
        default:  lfsr_nxt[J] = v26;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. A last byte needs the snapshot free, or freeing this cycle.
  // ---------------------------------------------------------------------------
  assign out_fire   = busy_r && out_chan.ready;
  assign drain_done = out_fire && (rem_r == CNT_W'(1));
  assign in_chan.ready = !busy_r || !in_chan.last_byte || drain_done;
  assign in_fire    = in_chan.valid && in_chan.ready;
  assign load       = in_fire && in_chan.last_byte;

  // Absorb the byte; clear the whole register once the block ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
        lfsr_r[i] <= '0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
        lfsr_r[i] <= load ? '0 : lfsr_nxt[i];
      end
    end
  end

  // Snapshot of the finished parity; shift down one byte per output transfer.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
        snap_r[i] <= lfsr_nxt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_PARITY - 1; i++) begin
        snap_r[i] <= snap_r[i+1];
      end
      snap_r[MAX_PARITY-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      rem_r  <= n_cur;
    end else if (out_fire) begin
      busy_r <= !drain_done;
      rem_r  <= rem_r - CNT_W'(1);
    end
  end

  assign out_chan.valid       = busy_r;
  assign out_chan.parity_byte = snap_r[0];
  assign out_chan.last_parity = (rem_r == CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || drain_done))
    else $error("parity snapshot overwritten before drain finished");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0))
    else $error("output valid with no parity bytes remaining");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && (rem_r == $past(n_cur))))
    else $error("parity count not loaded from active mode");

  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_done && !load) |=> !busy_r)
    else $error("output still valid after final parity transfer");

  a_lfsr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (lfsr_r[0] == '0))
    else $error("LFSR not cleared at end of block");

endmodule

`default_nettype wire
